// ===== src/gpr_pkg.sv =====
// Shared constants, cell record and codes of the grid potential relaxation unit.
package gpr_pkg;

	localparam int GRID_SIDE = 64;
	localparam int COORD_W   = 6;
	localparam int ADDR_W    = 2 * COORD_W;
	localparam int FRAC_BITS = 16;
	localparam int POT_W     = 18;
	localparam int PREF_W    = 18;
	localparam int GRAD_W    = 16;
	localparam int TV_W      = 32;
	localparam int DIFF_W    = POT_W + 1;          // difference of two potentials
	localparam int SQ_W      = 2 * POT_W;          // squared difference magnitude
	localparam int NORM_W    = SQ_W + 1;           // sum of two squares
	localparam int PROD_W    = PREF_W + DIFF_W;    // pref times gradient sum
	localparam int EDC_SH    = FRAC_BITS + 3;      // divide by 8 and drop fraction
	localparam int QUO_W     = 31;                 // floor(a * 2^30 / b), a <= b
	localparam int MAG_W     = GRAD_W - 1;

	localparam logic [COORD_W-1:0] COORD_MIN = COORD_W'(1);
	localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(GRID_SIDE - 2);

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_SWEEP = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	localparam logic [1:0] STAT_ACK   = 2'd0;
	localparam logic [1:0] STAT_READ  = 2'd1;
	localparam logic [1:0] STAT_SWEEP = 2'd2;

	localparam logic [1:0] KIND_FREE = 2'd0;

	typedef struct packed {
		logic [1:0]              kind;
		logic                    visited;
		logic signed [POT_W-1:0] pot;
		logic [PREF_W-1:0]       pref;
	} cell_t;

endpackage

// ===== src/gpr_norm_unit.sv =====
// Unit-vector component magnitude: isqrt(floor(a * 2^30 / b)), one bit per cycle.
module gpr_norm_unit
	import gpr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQ_W-1:0]   num,
	input  logic [NORM_W-1:0] den,
	output logic              done,
	output logic [MAG_W-1:0]  mag
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_DIV  = 2'd1;
	localparam logic [1:0] PH_SQRT = 2'd2;

	logic [1:0]        phase_q;
	logic [NORM_W:0]   rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic [4:0]        cnt_q;
	logic [QUO_W-1:0]  bit_q;
	logic [QUO_W:0]    res_q;
	logic              done_q;
	logic [MAG_W-1:0]  mag_q;

	logic [NORM_W:0]   trial;
	logic              ge;
	logic [QUO_W:0]    rb;
	logic              take;
	logic [QUO_W:0]    res_next;

	// restoring division step
	always_comb begin
		trial = (cnt_q == 5'd0) ? rem_q : {rem_q[NORM_W-1:0], 1'b0};
		ge    = trial >= {1'b0, den};
	end

	// square root digit step
	always_comb begin
		rb       = res_q + {1'b0, bit_q};
		take     = {1'b0, quo_q} >= rb;
		res_next = take ? ((res_q >> 1) + {1'b0, bit_q}) : (res_q >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				PH_IDLE: begin
					if (start) begin
						rem_q   <= {2'b0, num};
						quo_q   <= '0;
						cnt_q   <= '0;
						phase_q <= PH_DIV;
					end
				end
				PH_DIV: begin
					rem_q <= ge ? (trial - {1'b0, den}) : trial;
					quo_q <= {quo_q[QUO_W-2:0], ge};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(QUO_W - 1)) begin
						bit_q   <= {1'b1, {(QUO_W-1){1'b0}}};
						res_q   <= '0;
						phase_q <= PH_SQRT;
					end
				end
				PH_SQRT: begin
					if (take)
						quo_q <= quo_q - rb[QUO_W-1:0];
					res_q <= res_next;
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						mag_q   <= (res_next > (QUO_W+1)'(2**MAG_W - 1)) ?
							{MAG_W{1'b1}} : res_next[MAG_W-1:0];
						done_q  <= 1'b1;
						phase_q <= PH_IDLE;
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign mag  = mag_q;

endmodule

// ===== src/grid_potential_relaxation_unit.sv =====
// Grid potential relaxation unit: 64x64 cell store with Gauss-Seidel sweep and gradient read.
// A cell write goes straight to the output stage. A sweep visits the clamped box, at most
// 62x62 cells, column by column; each free cell is read as center and four neighbors through
// the single memory read port, then mean, multiply, saturate and write back follow, while a
// skipped cell costs only its center read. A read ends after its center read at the
// border or for a cell that is not updated; otherwise the two gradient components go in turn
// through one shared divide and square root unit at one bit per cycle. The block takes no new
// item until the current one has its result in the output register.
module grid_potential_relaxation_unit
	import gpr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// cell_x, cell_y, cell_kind, cell_visited, cell_pot, cell_pref,
	// box_min_x, box_max_x, box_min_y, box_max_y
	input  logic [79:0] s_tdata,
	// req_type
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_pot, grad_x, grad_y, total_variation
	output logic [87:0] m_tdata,
	// status
	output logic [1:0]  m_tuser,
	input  logic        cfg_we,
	input  logic        cfg_wdata
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RC   = 4'd1;
	localparam logic [3:0] ST_RL   = 4'd2;
	localparam logic [3:0] ST_RR   = 4'd3;
	localparam logic [3:0] ST_RD   = 4'd4;
	localparam logic [3:0] ST_RU   = 4'd5;
	localparam logic [3:0] ST_M0   = 4'd6;
	localparam logic [3:0] ST_M1   = 4'd7;
	localparam logic [3:0] ST_M2   = 4'd8;
	localparam logic [3:0] ST_WR   = 4'd9;
	localparam logic [3:0] ST_G0   = 4'd10;
	localparam logic [3:0] ST_G1   = 4'd11;
	localparam logic [3:0] ST_G2   = 4'd12;
	localparam logic [3:0] ST_GX   = 4'd13;
	localparam logic [3:0] ST_GY   = 4'd14;
	localparam logic [3:0] ST_OUT  = 4'd15;

	localparam int CELLS = GRID_SIDE * GRID_SIDE;
	localparam int SUM_W = POT_W + 2;

	// input unpacking
	logic [COORD_W-1:0]      in_x, in_y, bx0, bx1, by0, by1;
	cell_t                   in_cell;
	logic                    s_fire;

	assign in_x            = s_tdata[5:0];
	assign in_y            = s_tdata[11:6];
	assign in_cell.kind    = s_tdata[13:12];
	assign in_cell.visited = s_tdata[14];
	assign in_cell.pot     = s_tdata[32:15];
	assign in_cell.pref    = s_tdata[50:33];
	assign bx0             = s_tdata[56:51];
	assign bx1             = s_tdata[62:57];
	assign by0             = s_tdata[68:63];
	assign by1             = s_tdata[74:69];

	logic [3:0]               state_q;
	logic                     mode_q;
	logic                     is_read_q;
	logic [COORD_W-1:0]       x_q, y_q, y0_q, x1_q, y1_q;
	cell_t                    mem [CELLS];
	cell_t                    rd_q;
	cell_t                    c_q;
	logic signed [POT_W-1:0]  l_q, r_q, d_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [DIFF_W-1:0]        e_q;
	logic [PROD_W-1:0]        prod_q;
	logic signed [POT_W-1:0]  nv_q;
	logic signed [DIFF_W-1:0] dx_q, dy_q;
	logic [SQ_W-1:0]          ax_q, ay_q;
	logic [1:0]               stat_q;
	logic signed [POT_W-1:0]  opot_q;
	logic signed [GRAD_W-1:0] gx_q, gy_q;
	logic [TV_W-1:0]          tv_q;
	logic                     m_tvalid_q;
	logic [1:0]               m_stat_q;
	logic [POT_W-1:0]         m_pot_q;
	logic [GRAD_W-1:0]        m_gx_q, m_gy_q;
	logic [TV_W-1:0]          m_tv_q;

	logic                     norm_start;
	logic                     norm_done;
	logic [MAG_W-1:0]         nmag;
	logic [NORM_W-1:0]        norm_sq;

	assign s_tready = (state_q == ST_IDLE);
	assign s_fire   = s_tvalid && s_tready;

	// clamped sweep box
	logic [COORD_W-1:0] cx0, cx1, cy0, cy1;
	always_comb begin
		cx0 = (bx0 < COORD_MIN) ? COORD_MIN : bx0;
		cy0 = (by0 < COORD_MIN) ? COORD_MIN : by0;
		cx1 = (bx1 > COORD_MAX) ? COORD_MAX : bx1;
		cy1 = (by1 > COORD_MAX) ? COORD_MAX : by1;
	end

	// memory addressing
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic              wr_en;
	cell_t             wr_data;
	always_comb begin
		case (state_q)
			ST_RL:   rd_addr = {y_q, x_q - COORD_W'(1)};
			ST_RR:   rd_addr = {y_q, x_q + COORD_W'(1)};
			ST_RD:   rd_addr = {y_q - COORD_W'(1), x_q};
			ST_RU:   rd_addr = {y_q + COORD_W'(1), x_q};
			default: rd_addr = {y_q, x_q};
		endcase
		wr_en   = (s_fire && s_tuser == REQ_WRITE) || (state_q == ST_WR);
		wr_addr = s_fire ? {in_y, in_x} : {y_q, x_q};
		wr_data = in_cell;
		if (!s_fire) begin
			wr_data     = c_q;
			wr_data.pot = nv_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	// center cell tests
	logic upd, border, last;
	always_comb begin
		upd    = (rd_q.kind == KIND_FREE) && (!mode_q || rd_q.visited);
		border = (x_q < COORD_MIN) || (y_q < COORD_MIN) || (x_q > COORD_MAX) || (y_q > COORD_MAX);
		last   = (x_q == x1_q) && (y_q == y1_q);
	end

	// sweep arithmetic
	logic signed [DIFF_W-1:0] dlr, ddu;
	logic [DIFF_W-1:0]        alr, adu;
	logic signed [SUM_W-1:0]  sum_c;
	logic signed [SUM_W:0]    nv_w;
	logic signed [DIFF_W-1:0] dchg;
	logic [DIFF_W-1:0]        achg;
	logic [TV_W:0]            tv_sum;
	always_comb begin
		dlr   = DIFF_W'(l_q) - DIFF_W'(r_q);
		ddu   = DIFF_W'(d_q) - DIFF_W'(rd_q.pot);
		alr   = dlr[DIFF_W-1] ? DIFF_W'(-dlr) : DIFF_W'(dlr);
		adu   = ddu[DIFF_W-1] ? DIFF_W'(-ddu) : DIFF_W'(ddu);
		sum_c = SUM_W'(l_q) + SUM_W'(r_q) + SUM_W'(d_q) + SUM_W'(rd_q.pot);
		nv_w  = (SUM_W+1)'(sum_q >>> 2)
			- $signed({3'b0, prod_q[PROD_W-1:EDC_SH]});
		dchg  = DIFF_W'(nv_q) - DIFF_W'(c_q.pot);
		achg  = dchg[DIFF_W-1] ? DIFF_W'(-dchg) : DIFF_W'(dchg);
		tv_sum = {1'b0, tv_q} + (TV_W+1)'(achg);
	end

	// gradient norm unit
	assign norm_sq    = NORM_W'(ax_q) + NORM_W'(ay_q);
	assign norm_start = ((state_q == ST_G2) && (norm_sq != '0)) ||
		((state_q == ST_GX) && norm_done);

	gpr_norm_unit u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_start),
		.num    ((state_q == ST_G2) ? ax_q : ay_q),
		.den    (norm_sq),
		.done   (norm_done),
		.mag    (nmag)
	);

	logic signed [GRAD_W-1:0] gmag;
	assign gmag = $signed({1'b0, nmag});

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= 1'b0;
		else if (cfg_we)
			mode_q <= cfg_wdata;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != ST_OUT)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						opot_q    <= '0;
						gx_q      <= '0;
						gy_q      <= '0;
						tv_q      <= '0;
						is_read_q <= (s_tuser == REQ_READ);
						case (s_tuser)
							REQ_WRITE: begin
								stat_q  <= STAT_ACK;
								state_q <= ST_OUT;
							end
							REQ_SWEEP: begin
								stat_q <= STAT_SWEEP;
								x1_q   <= cx1;
								y0_q   <= cy0;
								y1_q   <= cy1;
								x_q    <= cx0;
								y_q    <= cy0;
								state_q <= (cx0 > cx1 || cy0 > cy1) ? ST_OUT : ST_RC;
							end
							REQ_READ: begin
								stat_q  <= STAT_READ;
								x_q     <= in_x;
								y_q     <= in_y;
								state_q <= ST_RC;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_RC: state_q <= ST_RL;
				ST_RL: begin
					c_q <= rd_q;
					if (is_read_q) begin
						opot_q  <= rd_q.pot;
						state_q <= (border || !upd) ? ST_OUT : ST_RR;
					end else if (upd) begin
						state_q <= ST_RR;
					end else if (last) begin
						state_q <= ST_OUT;
					end else begin
						x_q     <= (y_q == y1_q) ? x_q + COORD_W'(1) : x_q;
						y_q     <= (y_q == y1_q) ? y0_q : y_q + COORD_W'(1);
						state_q <= ST_RC;
					end
				end
				ST_RR: begin
					l_q     <= rd_q.pot;
					state_q <= ST_RD;
				end
				ST_RD: begin
					r_q     <= rd_q.pot;
					state_q <= ST_RU;
				end
				ST_RU: begin
					d_q     <= rd_q.pot;
					state_q <= ST_M0;
				end
				ST_M0: begin
					sum_q   <= sum_c;
					e_q     <= alr + adu;
					dx_q    <= dlr;
					dy_q    <= ddu;
					state_q <= is_read_q ? ST_G0 : ST_M1;
				end
				ST_M1: begin
					prod_q  <= PROD_W'(c_q.pref) * PROD_W'(e_q);
					state_q <= ST_M2;
				end
				ST_M2: begin
					if (nv_w > (SUM_W+1)'(2**(POT_W-1) - 1))
						nv_q <= {1'b0, {(POT_W-1){1'b1}}};
					else if (nv_w < -(SUM_W+1)'(2**(POT_W-1)))
						nv_q <= {1'b1, {(POT_W-1){1'b0}}};
					else
						nv_q <= nv_w[POT_W-1:0];
					state_q <= ST_WR;
				end
				ST_WR: begin
					tv_q <= tv_sum[TV_W] ? {TV_W{1'b1}} : tv_sum[TV_W-1:0];
					if (last) begin
						state_q <= ST_OUT;
					end else begin
						x_q     <= (y_q == y1_q) ? x_q + COORD_W'(1) : x_q;
						y_q     <= (y_q == y1_q) ? y0_q : y_q + COORD_W'(1);
						state_q <= ST_RC;
					end
				end
				ST_G0: begin
					ax_q    <= SQ_W'($signed(dx_q) * $signed(dx_q));
					state_q <= ST_G1;
				end
				ST_G1: begin
					ay_q    <= SQ_W'($signed(dy_q) * $signed(dy_q));
					state_q <= ST_G2;
				end
				ST_G2: state_q <= (norm_sq == '0) ? ST_OUT : ST_GX;
				ST_GX: begin
					if (norm_done) begin
						gx_q    <= dx_q[DIFF_W-1] ? -gmag : gmag;
						state_q <= ST_GY;
					end
				end
				ST_GY: begin
					if (norm_done) begin
						gy_q    <= dy_q[DIFF_W-1] ? -gmag : gmag;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_stat_q   <= stat_q;
						m_pot_q    <= opot_q;
						m_gx_q     <= gx_q;
						m_gy_q     <= gy_q;
						m_tv_q     <= tv_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_stat_q;
	assign m_tdata  = {6'b0, m_tv_q, m_gy_q, m_gx_q, m_pot_q};

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the grid potential relaxation unit.
module testbench;
	import gpr_pkg::*;

	localparam int IDLE_LIMIT = 20000;    // longest quiet stretch is the long receiver hold-off
	localparam int PATCH_HI   = GRID_SIDE - 5;   // low corner of the upper 5x5 patch

	typedef struct {
		logic [1:0]  req;
		logic [5:0]  cx, cy;
		logic [1:0]  kind;
		logic        visited;
		logic [17:0] pot;
		logic [17:0] pref;
		logic [5:0]  bx0, bx1, by0, by1;
	} grid_req_t;

	typedef struct {
		logic [1:0]  status;
		logic [17:0] pot;
		logic [15:0] gx, gy;
		logic [31:0] tv;
	} grid_res_t;

	// Grid predictor plus the queue of expected results
	class grid_scoreboard;
		longint    pot_mem[GRID_SIDE*GRID_SIDE];
		bit [1:0]  kind_mem[GRID_SIDE*GRID_SIDE];
		bit        vis_mem[GRID_SIDE*GRID_SIDE];
		longint    pref_mem[GRID_SIDE*GRID_SIDE];
		bit        mode;
		grid_res_t pending[$];
		int        errors;
		int        n_write, n_read, n_sweep, n_ignored;

		function bit free_cell(int idx);
			if (kind_mem[idx] != KIND_FREE)
				return 0;
			return mode == 0 || vis_mem[idx];
		endfunction

		function longint pot_xy(int x, int y);
			return pot_mem[y*GRID_SIDE + x];
		endfunction

		function longint int_sqrt(longint v);
			longint res, bitv;
			res  = 0;
			bitv = longint'(1) << 62;
			while (bitv > v)
				bitv = bitv >> 2;
			while (bitv != 0) begin
				if (v >= res + bitv) begin
					v   = v - (res + bitv);
					res = (res >> 1) + bitv;
				end else
					res = res >> 1;
				bitv = bitv >> 2;
			end
			return res;
		endfunction

		// one component of the unit vector, 15 fraction bits
		function logic [15:0] unit_part(longint d, longint sq, longint norm);
			logic [127:0] num;
			longint       g;
			num = 128'(sq) << 30;
			g   = int_sqrt(longint'(num / 128'(norm)));
			if (g > 32767)
				g = 32767;
			return d < 0 ? 16'(-g) : 16'(g);
		endfunction

		function longint relax_box(int bx0, int bx1, int by0, int by1);
			longint tv, l, r, d, u, mean, drag, nv;
			int     x0, x1, y0, y1, idx;
			tv = 0;
			x0 = bx0 < 1 ? 1 : bx0;
			y0 = by0 < 1 ? 1 : by0;
			x1 = bx1 > GRID_SIDE-2 ? GRID_SIDE-2 : bx1;
			y1 = by1 > GRID_SIDE-2 ? GRID_SIDE-2 : by1;
			for (int i = x0; i <= x1; i++) begin
				for (int j = y0; j <= y1; j++) begin
					idx = j*GRID_SIDE + i;
					if (free_cell(idx)) begin
						l    = pot_xy(i-1, j);
						r    = pot_xy(i+1, j);
						d    = pot_xy(i, j-1);
						u    = pot_xy(i, j+1);
						mean = (l + r + d + u) >>> 2;
						drag = (pref_mem[idx] * ((l > r ? l-r : r-l) + (d > u ? d-u : u-d))) >> 19;
						nv   = mean - drag;
						if (nv > 131071)
							nv = 131071;
						if (nv < -131072)
							nv = -131072;
						tv += nv > pot_mem[idx] ? nv - pot_mem[idx] : pot_mem[idx] - nv;
						if (tv > 64'hFFFF_FFFF)
							tv = 64'hFFFF_FFFF;
						pot_mem[idx] = nv;
					end
				end
			end
			return tv;
		endfunction

		function void note_item(grid_req_t q);
			grid_res_t e;
			int        idx, x, y;
			longint    dx, dy;
			e   = '{status: STAT_ACK, pot: '0, gx: '0, gy: '0, tv: '0};
			x   = q.cx;
			y   = q.cy;
			idx = y*GRID_SIDE + x;
			case (q.req)
				REQ_WRITE: begin
					kind_mem[idx] = q.kind;
					vis_mem[idx]  = q.visited;
					pot_mem[idx]  = longint'($signed(q.pot));
					pref_mem[idx] = q.pref;
					n_write++;
				end
				REQ_SWEEP: begin
					e.status = STAT_SWEEP;
					e.tv     = 32'(relax_box(q.bx0, q.bx1, q.by0, q.by1));
					n_sweep++;
				end
				REQ_READ: begin
					e.status = STAT_READ;
					e.pot    = 18'(pot_mem[idx]);
					if (x >= 1 && y >= 1 && x <= GRID_SIDE-2 && y <= GRID_SIDE-2 &&
					    free_cell(idx)) begin
						dx = pot_xy(x-1, y) - pot_xy(x+1, y);
						dy = pot_xy(x, y-1) - pot_xy(x, y+1);
						if (dx*dx + dy*dy != 0) begin
							e.gx = unit_part(dx, dx*dx, dx*dx + dy*dy);
							e.gy = unit_part(dy, dy*dy, dx*dx + dy*dy);
						end
					end
					n_read++;
				end
				default: begin
					n_ignored++;
					return;
				end
			endcase
			pending.push_back(e);
		endfunction

		function void check_result(grid_res_t a);
			grid_res_t e;
			if (pending.size() == 0) begin
				$error("unexpected result: status %0d", a.status);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, a.status);
				errors++;
			end
			if (a.pot !== e.pot) begin
				$error("out_pot: expected %0d, got %0d", $signed(e.pot), $signed(a.pot));
				errors++;
			end
			if (a.gx !== e.gx) begin
				$error("grad_x: expected %0d, got %0d", $signed(e.gx), $signed(a.gx));
				errors++;
			end
			if (a.gy !== e.gy) begin
				$error("grad_y: expected %0d, got %0d", $signed(e.gy), $signed(a.gy));
				errors++;
			end
			if (a.tv !== e.tv) begin
				$error("total_variation: expected %0d, got %0d", e.tv, a.tv);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid, s_tready;
	logic [79:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid, m_tready;
	logic [87:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_we, cfg_wdata;

	grid_scoreboard board;
	int          send_idle, recv_idle;
	bit          hold_req;
	int          idle_cycles;

	grid_potential_relaxation_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// accepted items go to the predictor, results to the checker
	always @(posedge clk) begin
		grid_req_t q;
		grid_res_t a;
		if (m_tvalid && m_tready) begin
			a.pot    = m_tdata[17:0];
			a.gx     = m_tdata[33:18];
			a.gy     = m_tdata[49:34];
			a.tv     = m_tdata[81:50];
			a.status = m_tuser;
			board.check_result(a);
		end
		if (s_tvalid && s_tready) begin
			q.req     = s_tuser;
			q.cx      = s_tdata[5:0];
			q.cy      = s_tdata[11:6];
			q.kind    = s_tdata[13:12];
			q.visited = s_tdata[14];
			q.pot     = s_tdata[32:15];
			q.pref    = s_tdata[50:33];
			q.bx0     = s_tdata[56:51];
			q.bx1     = s_tdata[62:57];
			q.by0     = s_tdata[68:63];
			q.by1     = s_tdata[74:69];
			board.note_item(q);
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
			$display("** grid_potential_relaxation_unit: FAILED **");
			$finish;
		end
	end

	// receiver: random stalls plus one long hold-off on request
	always @(negedge clk) begin
		int hold;
		if (hold_req && hold == 0) begin
			hold     = 600;
			hold_req = 0;
		end
		if (hold > 0) begin
			hold--;
			m_tready = 1'b0;
		end else
			m_tready = ($urandom_range(99) >= recv_idle);
	end

	task automatic send_item(grid_req_t q);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = q.req;
		s_tdata  = {5'd0, q.by1, q.by0, q.bx1, q.bx0, q.pref, q.pot, q.visited, q.kind,
		            q.cy, q.cx};
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid = 1'b0;
		while (board.pending.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_mode(bit v);
		drain();
		repeat (150) @(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = v;
		board.mode = v;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic grid_req_t cell_write(int x, int y, int kind, bit vis, int pot, int pref);
		grid_req_t q;
		q         = '{default: '0};
		q.req     = REQ_WRITE;
		q.cx      = 6'(x);
		q.cy      = 6'(y);
		q.kind    = 2'(kind);
		q.visited = vis;
		q.pot     = 18'(pot);
		q.pref    = 18'(pref);
		// unused box fields still carry noise
		q.bx0 = 6'($urandom);
		q.by1 = 6'($urandom);
		return q;
	endfunction

	function automatic grid_req_t cell_read(int x, int y);
		grid_req_t q;
		q     = '{default: '0};
		q.req = REQ_READ;
		q.cx  = 6'(x);
		q.cy  = 6'(y);
		return q;
	endfunction

	function automatic grid_req_t sweep(int x0, int x1, int y0, int y1);
		grid_req_t q;
		q     = '{default: '0};
		q.req = REQ_SWEEP;
		q.cx  = 6'($urandom);
		q.bx0 = 6'(x0);
		q.bx1 = 6'(x1);
		q.by0 = 6'(y0);
		q.by1 = 6'(y1);
		return q;
	endfunction

	// writes land in one of the two 5x5 corner patches; reads and sweep boxes stay
	// one cell inside them so every neighbor they touch has been loaded
	function automatic grid_req_t random_item();
		grid_req_t q;
		int        pick, base, lo, hi;
		pick = $urandom_range(99);
		base = $urandom_range(1) ? PATCH_HI : 0;
		lo   = base == 0 ? 0 : PATCH_HI + 1;
		hi   = base == 0 ? 3 : GRID_SIDE - 1;
		if (pick < 40) begin
			q = cell_write(base + $urandom_range(4), base + $urandom_range(4),
			               $urandom_range(3) == 0 ? $urandom_range(3) : KIND_FREE,
			               $urandom_range(1), $urandom, $urandom);
			// a fair share of small potentials and weights keeps sweeps near balance
			if ($urandom_range(1))
				q.pot = 18'($signed(14'($urandom)));
			if ($urandom_range(1))
				q.pref = 18'($urandom_range(65535));
		end else if (pick < 75)
			q = cell_read($urandom_range(hi, lo), $urandom_range(hi, lo));
		else if (pick < 95)
			q = sweep($urandom_range(hi, lo), $urandom_range(hi, lo),
			          $urandom_range(hi, lo), $urandom_range(hi, lo));
		else begin
			q     = cell_read($urandom_range(63), $urandom_range(63));
			q.req = 2'd3;
		end
		return q;
	endfunction

	initial begin
		board     = new();
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = REQ_WRITE;
		cfg_we    = 1'b0;
		cfg_wdata = 1'b0;
		m_tready  = 1'b0;
		hold_req  = 0;
		send_idle = 0;
		recv_idle = 0;
		idle_cycles = 0;
		arst_n    = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		set_mode(1'b0);

		// load both corner patches; every read and sweep stays inside them
		for (int j = 0; j < 5; j++)
			for (int i = 0; i < 5; i++) begin
				send_item(cell_write(i, j, $urandom_range(3) == 0 ? $urandom_range(3) : 0,
				                     $urandom_range(1), $signed(15'($urandom)),
				                     $urandom_range(32767)));
				send_item(cell_write(PATCH_HI + i, PATCH_HI + j,
				                     $urandom_range(3) == 0 ? $urandom_range(3) : 0,
				                     $urandom_range(1), $signed(15'($urandom)),
				                     $urandom_range(32767)));
			end

		// directed: field extremes, every request, clamping, border and blocked reads
		send_item(cell_write(0, 0, 1, 1, -131072, 262143));
		send_item(cell_write(63, 63, 3, 0, 131071, 0));
		send_item(cell_write(2, 2, 0, 1, 131071, 262143));
		send_item(cell_write(1, 2, 0, 0, -131072, 0));
		send_item(cell_write(3, 2, 0, 1, 131071, 0));
		send_item(cell_write(2, 1, 2, 0, 0, 0));
		send_item(cell_write(2, 3, 0, 0, 0, 0));
		send_item(cell_write(61, 61, 0, 0, 100, 0));
		send_item(cell_write(60, 61, 0, 0, 100, 0));
		send_item(cell_write(62, 61, 0, 0, 100, 0));
		send_item(cell_write(61, 60, 0, 0, 100, 0));
		send_item(cell_write(61, 62, 0, 0, 100, 0));
		send_item(cell_read(61, 61));
		send_item(cell_read(2, 2));
		send_item(cell_read(1, 2));
		send_item(cell_read(2, 1));
		send_item(cell_read(0, 0));
		send_item(cell_read(63, 63));
		send_item(sweep(0, 3, 0, 3));
		send_item(sweep(3, 1, 0, 3));
		send_item(sweep(60, 63, 60, 63));
		send_item(cell_read(2, 2));
		begin
			grid_req_t q;
			q     = cell_read(63, 0);
			q.req = 2'd3;
			send_item(q);
		end

		// random phases: receiver-heavy idling, sender-heavy idling, none
		for (int ph = 0; ph < 3; ph++) begin
			set_mode(ph != 1);
			send_idle = ph == 0 ? 30 : ph == 1 ? 82 : 0;
			recv_idle = ph == 0 ? 82 : ph == 1 ? 30 : 0;
			if (ph == 0)
				hold_req = 1;
			for (int n = 0; n < 22; n++) begin
				send_item(random_item());
				if (ph == 1 && n == 10)
					drain();
			end
		end

		drain();
		repeat (200) @(negedge clk);
		$display("covered %0d writes, %0d reads, %0d sweeps and %0d ignored requests",
		         board.n_write, board.n_read, board.n_sweep, board.n_ignored);
		$display("in both update modes, with stalls on either side and one long hold-off");
		if (board.errors == 0 && board.pending.size() == 0)
			$display("** grid_potential_relaxation_unit: PASSED **");
		else
			$display("** grid_potential_relaxation_unit: FAILED **");
		$finish;
	end

endmodule
